// ----- sv/psch_pkg.sv -----
// Shared types and constants for the priority quantum scheduler.
// No dependencies; used by the scheduler core.
package psch_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 64;
    localparam logic [15:0] QUANTUM_RESET = 16'd100;
    localparam logic [15:0] PRIO_MAX = 16'hFFFF;

    localparam logic REQ_LOAD     = 1'b0;
    localparam logic REQ_DISPATCH = 1'b1;

    typedef struct packed {
        logic [23:0] rem;
        logic [15:0] prio;
        logic [31:0] arr;
        logic [15:0] id;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

endpackage

// ----- sv/psch_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module psch_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/priority_quantum_scheduler_core.sv -----
// Top level of the priority quantum scheduler: sequencer around one record RAM.
// Depends on psch_pkg and psch_ram.
//
// The queue is a circular buffer in one RAM with a registered read;
// a sequencer scans it for the insertion point one entry per cycle and then
// moves the tail up one entry per cycle before it writes the new entry. A
// load into a full queue, or a dispatch from an empty queue, is dropped in
// its accept cycle. A dispatch reads the head entry; a process that is left
// unfinished is then re-inserted as a load is before the result register is
// loaded, and a finished process goes straight to the result register. Items are taken one
// at a time, and a dispatch whose result register still holds a transfer
// waits until that transfer is taken.
module priority_quantum_scheduler_core #(
    parameter int unsigned QUEUE_DEPTH = psch_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: proc_id[15:0], arrival_time[31:0], start_priority[15:0],
    // work_cycles[23:0].
    input  logic [87:0] s_axis_tdata,
    // Fields from bit 0: req_type.
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0: out_id[15:0], out_priority[15:0], cycles_run[15:0],
    // finished, queue_empty, six zero bits.
    output logic [55:0] m_axis_tdata
);
    import psch_pkg::*;

    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_SHIFT = 3'd2;
    localparam logic [2:0] ST_PUT   = 3'd3;
    localparam logic [2:0] ST_HEAD  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_k, n_k;
    logic          r_reins, n_reins;
    t_entry        r_key, n_key;
    logic [15:0]   r_quantum;
    logic [15:0]   r_res_id, n_res_id;
    logic [15:0]   r_res_prio, n_res_prio;
    logic [15:0]   r_res_run, n_res_run;
    logic          r_res_done, n_res_done;
    logic          r_ovalid, n_ovalid;
    logic [55:0]   r_odata, n_odata;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    t_entry        wdata, rdata;
    logic [ENTRY_W-1:0] rdata_raw;
    logic          in_xfer, after;
    logic [15:0]   run;
    logic [23:0]   rem_left;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] idx);
        logic [AW:0] s;
        s = {1'b0, head} + {1'b0, idx[AW-1:0]};
        if (s >= (AW+1)'(QUEUE_DEPTH)) begin
            s = s - (AW+1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    psch_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_raw)
    );
    assign rdata = t_entry'(rdata_raw);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    assign after = (rdata.prio < r_key.prio) ||
                   ((rdata.prio == r_key.prio) && (r_reins || (rdata.arr <= r_key.arr)));
    assign run      = (rdata.rem < {8'd0, r_quantum}) ? rdata.rem[15:0] : r_quantum;
    assign rem_left = rdata.rem - {8'd0, run};

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_pos      = r_pos;
        n_k        = r_k;
        n_reins    = r_reins;
        n_key      = r_key;
        n_res_id   = r_res_id;
        n_res_prio = r_res_prio;
        n_res_run  = r_res_run;
        n_res_done = r_res_done;
        n_ovalid   = r_ovalid && !m_axis_tready;
        n_odata    = r_odata;
        we         = 1'b0;
        waddr      = phys(r_head, r_k);
        wdata      = rdata;
        raddr      = phys(r_head, '0);
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_axis_tuser == REQ_LOAD) begin
                        n_key   = t_entry'(s_axis_tdata);
                        n_reins = 1'b0;
                        n_pos   = '0;
                        if (r_count == '0) begin
                            n_state = ST_PUT;
                        end else if (r_count != DEPTH_C) begin
                            n_state = ST_SCAN;
                        end
                    end else if (r_count != '0) begin
                        n_state = ST_HEAD;
                    end
                end
            end
            ST_HEAD: begin
                n_res_id   = rdata.id;
                n_res_prio = rdata.prio;
                n_res_run  = run;
                n_res_done = (rem_left == '0);
                n_head     = phys(r_head, CW'(1));
                n_count    = r_count - 1'b1;
                n_key.id   = rdata.id;
                n_key.arr  = rdata.arr;
                n_key.rem  = rem_left;
                n_key.prio = (rdata.prio == PRIO_MAX) ? PRIO_MAX : rdata.prio + 1'b1;
                n_reins    = 1'b1;
                n_pos      = '0;
                raddr      = phys(r_head, CW'(1));
                if (rem_left == '0) begin
                    n_state = ST_OUT;
                end else if (r_count == CW'(1)) begin
                    n_state = ST_PUT;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (after) begin
                    n_pos = r_pos + 1'b1;
                    raddr = phys(r_head, r_pos + 1'b1);
                    if (r_pos + 1'b1 == r_count) begin
                        n_state = ST_PUT;
                    end
                end else begin
                    n_k   = r_count;
                    raddr = phys(r_head, r_count - 1'b1);
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                we    = 1'b1;
                waddr = phys(r_head, r_k);
                wdata = rdata;
                n_k   = r_k - 1'b1;
                raddr = phys(r_head, r_k - 2'd2);
                if (r_k - 1'b1 == r_pos) begin
                    n_state = ST_PUT;
                end
            end
            ST_PUT: begin
                we      = 1'b1;
                waddr   = phys(r_head, r_pos);
                wdata   = r_key;
                n_count = r_count + 1'b1;
                n_state = r_reins ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (!n_ovalid) begin
                    n_ovalid = 1'b1;
                    n_odata  = {6'd0, (r_count == '0), r_res_done,
                                r_res_run, r_res_prio, r_res_id};
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_ovalid  <= 1'b0;
            r_quantum <= QUANTUM_RESET;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_quantum <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_k        <= n_k;
        r_reins    <= n_reins;
        r_key      <= n_key;
        r_res_id   <= n_res_id;
        r_res_prio <= n_res_prio;
        r_res_run  <= n_res_run;
        r_res_done <= n_res_done;
        r_odata    <= n_odata;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("queue count exceeds depth");

    a_shift_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT) |-> (r_k > r_pos))
        else $error("shift pointer passed insertion point");

    a_put_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUT) |-> (r_count != DEPTH_C) && (r_pos <= r_count))
        else $error("insert into full queue or past tail");
endmodule
